### hdl/hpv_pkg.sv
// Package for the host[:port] string checker.
// Holds beat types, character constants, register indexes and class functions.
// No dependencies.
package hpv_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned PORT_W  = 17;
  localparam int unsigned PROD_W  = 20;

  localparam logic [PORT_W-1:0]  PORT_LIMIT   = 17'd65536;
  localparam logic [COUNT_W-1:0] HOST_LEN_RST = 8'd253;
  localparam logic [COUNT_W-1:0] LABEL_LEN_RST = 8'd63;

  localparam logic [CHAR_W-1:0] CHR_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CHR_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CHR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHR_NINE  = 8'h39;

  typedef enum logic {
    REG_MAX_HOST  = 1'b0,
    REG_MAX_LABEL = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              final_byte;
  } hpv_beat_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CHR_ZERO) && (c <= CHR_NINE);
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

endpackage

### hdl/hpv_in_stage.sv
// Input register stage: captures one byte beat and holds it until the checker advances.
// Depends on hpv_pkg.
module hpv_in_stage
  import hpv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  hpv_beat_t in_beat,
  output logic      beat_valid,
  output hpv_beat_t beat,
  input  logic      advance
);

  logic      valid_r;
  logic      valid_nxt;
  hpv_beat_t beat_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule

### hdl/hpv_check.sv
// String state update and result register for the host[:port] checker.
// Depends on hpv_pkg; fed by hpv_in_stage.
module hpv_check
  import hpv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               beat_valid,
  input  hpv_beat_t          beat,
  output logic               advance,
  input  logic [COUNT_W-1:0] max_host_len,
  input  logic [COUNT_W-1:0] max_label_len,
  output logic               res_valid,
  output logic               res_ok,
  input  logic               res_ready
);

  logic               at_start_r, at_start_nxt;
  logic               in_port_r, in_port_nxt;
  logic [COUNT_W-1:0] host_cnt_r, host_cnt_nxt;
  logic [COUNT_W-1:0] label_cnt_r, label_cnt_nxt;
  logic               prev_alnum_r, prev_alnum_nxt;
  logic [PORT_W-1:0]  port_r, port_nxt;
  logic               port_seen_r, port_seen_nxt;
  logic               failed_r, failed_nxt;
  logic               res_valid_r, res_valid_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic               alnum;
  logic               digit;
  logic [PROD_W-1:0]  port_prod;
  logic               ok;

  assign advance   = !res_valid_r || res_ready;
  assign alnum     = is_alnum(beat.character);
  assign digit     = is_digit(beat.character);
  assign port_prod = ({3'b000, port_r} << 3) + ({3'b000, port_r} << 1)
                   + {{(PROD_W-CHAR_W){1'b0}}, beat.character - CHR_ZERO};

  always_comb begin
    at_start_nxt   = at_start_r;
    in_port_nxt    = in_port_r;
    host_cnt_nxt   = host_cnt_r;
    label_cnt_nxt  = label_cnt_r;
    prev_alnum_nxt = prev_alnum_r;
    port_nxt       = port_r;
    port_seen_nxt  = port_seen_r;
    failed_nxt     = failed_r;
    res_valid_nxt  = res_valid_r;
    res_ok_nxt     = res_ok_r;
    ok             = 1'b0;

    if (advance) begin
      res_valid_nxt = 1'b0;
    end

    if (beat_valid && advance) begin
      if (at_start_r) begin
        at_start_nxt = 1'b0;
        if (!alnum) begin
          failed_nxt = 1'b1;
        end
      end

      if (in_port_r) begin
        if (digit) begin
          port_nxt      = (port_prod > {3'b000, PORT_LIMIT}) ? PORT_LIMIT
                                                             : port_prod[PORT_W-1:0];
          port_seen_nxt = 1'b1;
        end else begin
          failed_nxt = 1'b1;
        end
      end else if (beat.character == CHR_COLON) begin
        in_port_nxt = 1'b1;
        if (!prev_alnum_r) begin
          failed_nxt = 1'b1;
        end
      end else begin
        if (host_cnt_r >= max_host_len) begin
          failed_nxt = 1'b1;
        end else begin
          host_cnt_nxt = host_cnt_r + 1'b1;
        end
        if (beat.character == CHR_DOT) begin
          label_cnt_nxt = '0;
        end else begin
          if (label_cnt_r >= max_label_len) begin
            failed_nxt = 1'b1;
          end else begin
            label_cnt_nxt = label_cnt_r + 1'b1;
          end
          if (!alnum && (beat.character != CHR_DASH)) begin
            failed_nxt = 1'b1;
          end
        end
        prev_alnum_nxt = alnum;
      end

      if (beat.final_byte) begin
        if (in_port_nxt) begin
          ok = !failed_nxt && port_seen_nxt && (port_nxt != '0) && (port_nxt < PORT_LIMIT);
        end else begin
          ok = !failed_nxt && prev_alnum_nxt;
        end
        res_valid_nxt  = 1'b1;
        res_ok_nxt     = ok;
        at_start_nxt   = 1'b1;
        in_port_nxt    = 1'b0;
        host_cnt_nxt   = '0;
        label_cnt_nxt  = '0;
        prev_alnum_nxt = 1'b0;
        port_nxt       = '0;
        port_seen_nxt  = 1'b0;
        failed_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r   <= 1'b1;
      in_port_r    <= 1'b0;
      host_cnt_r   <= '0;
      label_cnt_r  <= '0;
      prev_alnum_r <= 1'b0;
      port_r       <= '0;
      port_seen_r  <= 1'b0;
      failed_r     <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      at_start_r   <= at_start_nxt;
      in_port_r    <= in_port_nxt;
      host_cnt_r   <= host_cnt_nxt;
      label_cnt_r  <= label_cnt_nxt;
      prev_alnum_r <= prev_alnum_nxt;
      port_r       <= port_nxt;
      port_seen_r  <= port_seen_nxt;
      failed_r     <= failed_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_ok_r <= res_ok_nxt;
  end

  assign res_valid = res_valid_r;
  assign res_ok    = res_ok_r;

endmodule

### hdl/hostname_port_validator_top.sv
// Channel   Dir  Beat contents                     End of string
// in_       in   tdata[7:0] character              tlast = final byte
// out_      out  tdata[0] valid_res, [7:1] zero    one beat per string
// cfg_      in   index 0 max host len, 1 max label len (8 bits)
//
// One byte per cycle sustained while results are taken; each beat passes the
// input register and then the state update into the result register, so a
// result is valid once its final byte has passed both. Reset restores 253/63
// and clears string state. A held result stalls the input only once the
// input register is also full.
// Top level of the host[:port] checker; depends on hpv_pkg, hpv_in_stage, hpv_check.
module hostname_port_validator_top
  import hpv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [CHAR_W-1:0]  in_tdata,   // [7:0] character
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,  // [0] valid_res, [7:1] zero
  input  logic               cfg_wr_en,
  input  cfg_reg_t           cfg_index,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  logic [COUNT_W-1:0] max_host_r;
  logic [COUNT_W-1:0] max_label_r;
  hpv_beat_t          in_beat;
  hpv_beat_t          beat;
  logic               beat_valid;
  logic               advance;
  logic               res_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_host_r  <= HOST_LEN_RST;
      max_label_r <= LABEL_LEN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MAX_HOST:  max_host_r  <= cfg_wdata;
        REG_MAX_LABEL: max_label_r <= cfg_wdata;
        default:       max_host_r  <= max_host_r;
      endcase
    end
  end

  assign in_beat.character  = in_tdata;
  assign in_beat.final_byte = in_tlast;

  hpv_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_beat    (in_beat),
    .beat_valid (beat_valid),
    .beat       (beat),
    .advance    (advance)
  );

  hpv_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .beat_valid    (beat_valid),
    .beat          (beat),
    .advance       (advance),
    .max_host_len  (max_host_r),
    .max_label_len (max_label_r),
    .res_valid     (out_tvalid),
    .res_ok        (res_ok),
    .res_ready     (out_tready)
  );

  assign out_tdata = {7'b0000000, res_ok};

endmodule

### verif/hostname_port_validator_top_tb.sv
`timescale 1ns / 100ps
// Testbench for hostname_port_validator_top: streams host[:port] strings byte by byte and
// checks each verdict beat against an in-bench tracker of the string rules.
// Depends on hpv_pkg and the RTL under hdl.
module hostname_port_validator_top_tb;
  import hpv_pkg::*;

  typedef logic [CHAR_W-1:0] chr_q_t[$];

  localparam int LIMIT       = 250000;
  localparam int HOLD_CYCLES = 300;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [CHAR_W-1:0]  in_tdata   = '0;   // [7:0] character
  logic               in_tlast   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;         // [0] valid_res, [7:1] zero
  logic               cfg_wr_en  = 1'b0;
  cfg_reg_t           cfg_index  = REG_MAX_HOST;
  logic [COUNT_W-1:0] cfg_wdata  = '0;

  hpv_beat_t   byte_q[$];
  logic        valid_exp_q[$];
  hpv_beat_t   next_beat;
  logic        exp_valid;
  int          bytes_queued = 0;
  int          errors = 0;
  int          cycle_cnt = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;

  // string tracker state and its copy of the limits
  logic              hs_first, hs_port, hs_prev_alnum, hs_digit_seen, hs_bad;
  logic [COUNT_W-1:0] hs_host_cnt, hs_label_cnt;
  logic [PORT_W-1:0]  hs_port_val;
  logic [COUNT_W-1:0] lim_host = HOST_LEN_RST;
  logic [COUNT_W-1:0] lim_label = LABEL_LEN_RST;

  hostname_port_validator_top dut (.*);

  always #5 clk = ~clk;

  function automatic logic char_digit(input logic [CHAR_W-1:0] c);
    return c >= CHR_ZERO && c <= CHR_NINE;
  endfunction

  function automatic logic char_alnum(input logic [CHAR_W-1:0] c);
    return char_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [CHAR_W-1:0] rand_alnum();
    int r;
    r = $urandom_range(61);
    if (r < 10) return CHR_ZERO + CHAR_W'(r);
    else if (r < 36) return CHAR_W'("a" + (r - 10));
    else return CHAR_W'("A" + (r - 36));
  endfunction

  function void clear_host_state();
    hs_first      = 1'b1;
    hs_port       = 1'b0;
    hs_host_cnt   = '0;
    hs_label_cnt  = '0;
    hs_prev_alnum = 1'b0;
    hs_port_val   = '0;
    hs_digit_seen = 1'b0;
    hs_bad        = 1'b0;
  endfunction

  function void track_host_byte(input logic [CHAR_W-1:0] c, input logic last);
    logic        alnum;
    logic        ok;
    int unsigned v;
    alnum = char_alnum(c);
    if (hs_first) begin
      hs_first = 1'b0;
      if (!alnum) hs_bad = 1'b1;
    end
    if (hs_port) begin
      if (char_digit(c)) begin
        v = hs_port_val * 10 + (c - CHR_ZERO);
        hs_port_val = (v > PORT_LIMIT) ? PORT_LIMIT : v[PORT_W-1:0];
        hs_digit_seen = 1'b1;
      end else begin
        hs_bad = 1'b1;
      end
    end else if (c == CHR_COLON) begin
      hs_port = 1'b1;
      if (!hs_prev_alnum) hs_bad = 1'b1;
    end else begin
      if (hs_host_cnt >= lim_host) hs_bad = 1'b1;
      else hs_host_cnt++;
      if (c == CHR_DOT) begin
        hs_label_cnt = '0;
      end else begin
        if (hs_label_cnt >= lim_label) hs_bad = 1'b1;
        else hs_label_cnt++;
        if (!alnum && c != CHR_DASH) hs_bad = 1'b1;
      end
      hs_prev_alnum = alnum;
    end
    if (last) begin
      ok = !hs_bad;
      if (hs_port)
        ok = ok && hs_digit_seen && hs_port_val >= 1 && hs_port_val < PORT_LIMIT;
      else
        ok = ok && hs_prev_alnum;
      valid_exp_q = {valid_exp_q, ok};
      clear_host_state();
    end
  endfunction

  // sender: advance on handshake, hold otherwise
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) track_host_byte(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_beat = byte_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_beat.character;
          in_tlast  <= next_beat.final_byte;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (valid_exp_q.size() == 0) begin
        $display("%0t: unexpected verdict beat, expected none, got %h", $time, out_tdata);
        errors++;
      end else begin
        exp_valid = valid_exp_q.pop_front();
        if (out_tdata !== {7'd0, exp_valid}) begin
          $display("%0t: verdict mismatch, expected %h, got %h", $time, {7'd0, exp_valid},
                   out_tdata);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_bytes(input chr_q_t s);
    hpv_beat_t b;
    for (int i = 0; i < s.size(); i++) begin
      b.character  = s[i];
      b.final_byte = (i == s.size() - 1);
      byte_q = {byte_q, b};
    end
    bytes_queued += s.size();
  endtask

  task automatic queue_text(input string t);
    chr_q_t s;
    for (int i = 0; i < t.len(); i++) s = {s, t[i]};
    queue_bytes(s);
  endtask

  // dots at every period-th byte, letters elsewhere
  task automatic queue_long_host(input int n, input int period);
    chr_q_t s;
    for (int i = 0; i < n; i++) s = {s, ((i % period == period - 1) ? CHR_DOT : "a")};
    queue_bytes(s);
  endtask

  task automatic make_host(ref chr_q_t s);
    int    nlab, len, r, v;
    string ps;
    nlab = $urandom_range(1, 4);
    for (int k = 0; k < nlab; k++) begin
      if (k > 0) s = {s, CHR_DOT};
      r = $urandom_range(19);
      if (r < 14) len = $urandom_range(1, 6);
      else if (r < 17) len = (lim_label > 24) ? 24 : lim_label;
      else if (r < 19) len = (lim_label > 24) ? 25 : lim_label + 1;
      else len = (k == 0) ? 1 : 0;
      for (int i = 0; i < len; i++)
        if (i == 0 || i == len - 1 || $urandom_range(4) != 0) s = {s, rand_alnum()};
        else s = {s, CHR_DASH};
    end
    r = $urandom_range(9);
    if (r >= 5) begin
      s = {s, CHR_COLON};
      if (r != 9) begin
        case ($urandom_range(6))
          0: v = 0;
          1: v = 65535;
          2: v = 65536;
          3: v = $urandom_range(65536, 9999999);
          4: v = $urandom_range(1, 1023);
          default: v = $urandom_range(1, 65535);
        endcase
        ps = $sformatf("%0d", v);
        if ($urandom_range(4) == 0) ps = {"00", ps};
        for (int i = 0; i < ps.len(); i++) s = {s, ps[i]};
      end
    end
  endtask

  task automatic queue_random(input int budget);
    chr_q_t s;
    int     start, r;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      s.delete();
      r = $urandom_range(99);
      if (r < 15) begin
        repeat ($urandom_range(1, 8)) s = {s, CHAR_W'($urandom_range(255))};
      end else begin
        make_host(s);
        if (r < 30) s[$urandom_range(s.size() - 1)] = CHAR_W'($urandom_range(255));
      end
      queue_bytes(s);
    end
  endtask

  task automatic write_limits(input logic [COUNT_W-1:0] host_len,
                              input logic [COUNT_W-1:0] label_len);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_MAX_HOST;
    cfg_wdata <= host_len;
    @(posedge clk);
    cfg_index <= REG_MAX_LABEL;
    cfg_wdata <= label_len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    lim_host  = host_len;
    lim_label = label_len;
  endtask

  task automatic set_idling(input int send_idle, input int recv_stall);
    @(negedge clk);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || in_tvalid || valid_exp_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    clear_host_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // default limits, directed strings
    set_idling(0, 0);
    queue_text("a");
    queue_text("Z");
    queue_text("9");
    queue_text("-a");
    queue_text("a-");
    queue_text("host-1.example:8080");
    queue_text("a..b");
    queue_text("a.");
    queue_text(".a");
    queue_text("a b");
    queue_text("a:1");
    queue_text("a:0");
    queue_text("a:65535");
    queue_text("a:65536");
    queue_text("a:000080");
    queue_text("a:");
    queue_text("a::1");
    queue_text(":80");
    queue_text("a:99999999");
    queue_text("a:8a");
    queue_text("\377");
    queue_text("a\200b");
    queue_long_host(253, 64);
    queue_long_host(64, 65);
    wait_drained();

    write_limits(8'd255, 8'd255);
    set_idling(57, 0);
    queue_long_host(256, 300);
    queue_random(50);
    wait_drained();

    write_limits(8'd1, 8'd1);
    set_idling(0, 57);
    queue_random(50);
    wait_drained();

    write_limits($urandom_range(4, 40), $urandom_range(1, 12));
    set_idling(18, 18);
    queue_random(50);
    wait_drained();

    // default limits again; receiver holds off while the sender keeps offering
    write_limits(HOST_LEN_RST, LABEL_LEN_RST);
    set_idling(0, 0);
    hold_req = hold_req + 1;
    queue_random(50);
    wait_drained();

    set_idling(57, 57);
    queue_random(50);
    wait_drained();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
